>>> sv/cpr_pkg.sv
`default_nettype none

package cpr_pkg;

	localparam int ITER_DEF   = 16;
	localparam int WIDTH_DEF  = 16;
	localparam int MAX_STEPS  = 24;
	localparam int MAG_LIMIT  = 46341;
	localparam int HALF_PI    = 16384;

	// 1/K of the CORDIC gain, Q30
	localparam logic [29:0] GAIN_Q30 = 30'd652032874;

	// atan(2^-i), pi = 2^31
	localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum logic {
		OP_POLAR = 1'b0,
		OP_RECT  = 1'b1
	} op_t;

	typedef struct packed {
		op_t  op;
		logic zero;
	} ctrl_t;

endpackage

`default_nettype wire

>>> sv/cpr_prep.sv
`default_nettype none

module cpr_prep #(
	parameter int GUARD = 4,
	parameter int W     = 23
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    up_valid,
	output logic                   up_ready,
	input  wire                    op,
	input  wire  signed [15:0]     real_in,
	input  wire  signed [15:0]     imag_in,
	input  wire         [15:0]     magnitude_in,
	input  wire  signed [15:0]     phase_in,
	output logic                   dn_valid,
	input  wire                    dn_ready,
	output cpr_pkg::ctrl_t         dn_ctrl,
	output logic signed [W-1:0]    dn_x,
	output logic signed [W-1:0]    dn_y,
	output logic        [31:0]     dn_z
);

	localparam int PRW = 46;
	localparam int SW  = PRW + GUARD + 1;

	logic                  v_s1, v_s2;
	logic                  en1, en2;
	cpr_pkg::ctrl_t        ctrl_s1, ctrl_s2;
	logic signed [W-1:0]   x_s1, y_s1, x_s2, y_s2;
	logic        [31:0]    z_s1, z_s2;
	logic                  neg_s1;
	logic        [PRW-1:0] prod_s1;

	logic signed [W-1:0]   xe, ye;
	logic        [15:0]    magc;
	logic        [15:0]    pa;
	logic                  wrap;
	logic        [SW-1:0]  sum;
	logic        [W-1:0]   xmag;

	assign en2      = !v_s2 || dn_ready;
	assign en1      = !v_s1 || en2;
	assign up_ready = en1;

	always_comb begin
		xe   = W'(real_in) <<< GUARD;
		ye   = W'(imag_in) <<< GUARD;
		magc = (magnitude_in > 16'(cpr_pkg::MAG_LIMIT)) ? 16'(cpr_pkg::MAG_LIMIT)
		                                                : magnitude_in;
		// outside +-pi/2 the phase moves by pi: only the top bit flips
		wrap = (phase_in > 16'sd16384) || (phase_in < -16'sd16384);
		pa   = wrap ? {~phase_in[15], phase_in[14:0]} : phase_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= up_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && up_valid) begin
			ctrl_s1.op   <= cpr_pkg::op_t'(op);
			ctrl_s1.zero <= (op == cpr_pkg::OP_POLAR) && (real_in == 16'sd0) &&
			                (imag_in == 16'sd0);
			neg_s1       <= wrap;
			prod_s1      <= PRW'(magc) * PRW'(cpr_pkg::GAIN_Q30);
			if (op == cpr_pkg::OP_RECT) begin
				x_s1 <= xe;
				y_s1 <= ye;
				z_s1 <= {pa, 16'h0000};
			end else if (real_in < 16'sd0) begin
				x_s1 <= -xe;
				y_s1 <= -ye;
				z_s1 <= 32'h8000_0000;
			end else begin
				x_s1 <= xe;
				y_s1 <= ye;
				z_s1 <= 32'h0000_0000;
			end
		end
	end

	always_comb begin
		sum  = {1'b0, prod_s1, {GUARD{1'b0}}} + (SW'(1) << 29);
		xmag = W'(sum[SW-1:30]);
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			ctrl_s2 <= ctrl_s1;
			z_s2    <= z_s1;
			if (ctrl_s1.op == cpr_pkg::OP_RECT) begin
				x_s2 <= neg_s1 ? -$signed(xmag) : $signed(xmag);
				y_s2 <= '0;
			end else begin
				x_s2 <= x_s1;
				y_s2 <= y_s1;
			end
		end
	end

	assign dn_valid = v_s2;
	assign dn_ctrl  = ctrl_s2;
	assign dn_x     = x_s2;
	assign dn_y     = y_s2;
	assign dn_z     = z_s2;

endmodule

`default_nettype wire

>>> sv/cpr_rot.sv
`default_nettype none

module cpr_rot #(
	parameter int STEP = 0,
	parameter int W    = 23
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 up_valid,
	output logic                up_ready,
	input  wire cpr_pkg::ctrl_t up_ctrl,
	input  wire  signed [W-1:0] up_x,
	input  wire  signed [W-1:0] up_y,
	input  wire         [31:0]  up_z,
	output logic                dn_valid,
	input  wire                 dn_ready,
	output cpr_pkg::ctrl_t      dn_ctrl,
	output logic signed [W-1:0] dn_x,
	output logic signed [W-1:0] dn_y,
	output logic        [31:0]  dn_z
);

	localparam logic [31:0] ANGLE = cpr_pkg::ATAN_TAB[STEP];

	logic                v_s1;
	logic                en;
	cpr_pkg::ctrl_t      ctrl_s1;
	logic signed [W-1:0] x_s1, y_s1;
	logic        [31:0]  z_s1;
	logic signed [W-1:0] dx, dy;
	logic                turn_a;

	assign en       = !v_s1 || dn_ready;
	assign up_ready = en;

	// vectoring steers on the sign of y, rotation on the sign of z
	always_comb begin
		dx     = up_y >>> STEP;
		dy     = up_x >>> STEP;
		turn_a = (up_ctrl.op == cpr_pkg::OP_POLAR) ? !up_y[W-1] : up_z[31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && up_valid) begin
			ctrl_s1 <= up_ctrl;
			if (turn_a) begin
				x_s1 <= up_x + dx;
				y_s1 <= up_y - dy;
				z_s1 <= up_z + ANGLE;
			end else begin
				x_s1 <= up_x - dx;
				y_s1 <= up_y + dy;
				z_s1 <= up_z - ANGLE;
			end
		end
	end

	assign dn_valid = v_s1;
	assign dn_ctrl  = ctrl_s1;
	assign dn_x     = x_s1;
	assign dn_y     = y_s1;
	assign dn_z     = z_s1;

endmodule

`default_nettype wire

>>> sv/cpr_post.sv
`default_nettype none

module cpr_post #(
	parameter int GUARD = 4,
	parameter int W     = 23
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 up_valid,
	output logic                up_ready,
	input  wire cpr_pkg::ctrl_t up_ctrl,
	input  wire  signed [W-1:0] up_x,
	input  wire  signed [W-1:0] up_y,
	input  wire         [31:0]  up_z,
	output logic                valid,
	input  wire                 stall,
	output logic        [15:0]  magnitude_out,
	output logic signed [15:0]  phase_out,
	output logic signed [16:0]  real_out,
	output logic signed [16:0]  imag_out
);

	localparam int PMW = W + 31;

	localparam logic signed [PMW-1:0] MAG_RND = PMW'(1) <<< (29 + GUARD);
	localparam logic signed [PMW-1:0] MAG_MAX = PMW'(cpr_pkg::MAG_LIMIT);
	localparam logic signed [W:0]     PRT_RND = (W + 1)'(1) <<< (GUARD - 1);
	localparam logic signed [W:0]     PRT_MAX = (W + 1)'(cpr_pkg::MAG_LIMIT);
	localparam logic signed [W:0]     PRT_MIN = -PRT_MAX;

	logic                  v_s1, v_s2;
	logic                  en1, en2;
	cpr_pkg::ctrl_t        ctrl_s1;
	logic signed [PMW-1:0] prod_s1;
	logic signed [W:0]     xr_s1, yr_s1;
	logic        [15:0]    ph_s1;

	logic        [31:0]    zr;
	logic signed [W:0]     xs, ys;
	logic signed [PMW-1:0] mag;
	logic signed [W:0]     xc, yc;

	assign en2      = !v_s2 || !stall;
	assign en1      = !v_s1 || en2;
	assign up_ready = en1;

	always_comb begin
		zr = up_z + 32'h0000_8000;
		xs = ((W + 1)'(up_x) + PRT_RND) >>> GUARD;
		ys = ((W + 1)'(up_y) + PRT_RND) >>> GUARD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= up_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && up_valid) begin
			ctrl_s1 <= up_ctrl;
			prod_s1 <= PMW'(up_x) * $signed(PMW'(cpr_pkg::GAIN_Q30));
			xr_s1   <= xs;
			yr_s1   <= ys;
			ph_s1   <= zr[31:16];
		end
	end

	always_comb begin
		mag = (prod_s1 + MAG_RND) >>> (30 + GUARD);
		if (xr_s1 > PRT_MAX)      xc = PRT_MAX;
		else if (xr_s1 < PRT_MIN) xc = PRT_MIN;
		else                      xc = xr_s1;
		if (yr_s1 > PRT_MAX)      yc = PRT_MAX;
		else if (yr_s1 < PRT_MIN) yc = PRT_MIN;
		else                      yc = yr_s1;
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			if (ctrl_s1.op == cpr_pkg::OP_RECT) begin
				magnitude_out <= '0;
				phase_out     <= '0;
				real_out      <= xc[16:0];
				imag_out      <= yc[16:0];
			end else begin
				real_out <= '0;
				imag_out <= '0;
				if (ctrl_s1.zero) begin
					magnitude_out <= '0;
					phase_out     <= '0;
				end else begin
					phase_out <= ph_s1;
					if (mag > MAG_MAX)      magnitude_out <= 16'(cpr_pkg::MAG_LIMIT);
					else if (mag < 0)       magnitude_out <= '0;
					else                    magnitude_out <= mag[15:0];
				end
			end
		end
	end

	assign valid = v_s2;

endmodule

`default_nettype wire

>>> sv/cordic_polar_rect_convert.sv
`default_nettype none

// channel  | handshake           | payload
// bin      | bin_valid/bin_stall | op, real_in, imag_in, magnitude_in, phase_in
// res      | res_valid/res_stall | magnitude_out, phase_out, real_out, imag_out
//
// One bin per cycle while res is not stalled; the pipe is two set-up stages
// (gain multiply, quadrant fold), one register per CORDIC micro-rotation,
// and two output stages (gain multiply, round and saturate).
// Reset clears the valid bits only.
// A stall on res holds the output register and backs up only through full
// stages, so empty stages still take new bins.

module cordic_polar_rect_convert #(
	parameter int ITERATIONS = cpr_pkg::ITER_DEF,
	parameter int DATA_WIDTH = cpr_pkg::WIDTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                bin_valid,
	output logic               bin_stall,
	input  wire                op,
	input  wire  signed [15:0] real_in,
	input  wire  signed [15:0] imag_in,
	input  wire         [15:0] magnitude_in,
	input  wire  signed [15:0] phase_in,
	output logic               res_valid,
	input  wire                res_stall,
	output logic        [15:0] magnitude_out,
	output logic signed [15:0] phase_out,
	output logic signed [16:0] real_out,
	output logic signed [16:0] imag_out
);

	localparam int GUARD = DATA_WIDTH / 4;
	localparam int W     = 19 + GUARD;
	localparam int N     = (ITERATIONS > cpr_pkg::MAX_STEPS) ? cpr_pkg::MAX_STEPS
	                                                         : ITERATIONS;

	logic                v_c    [N+1];
	logic                rdy_c  [N+1];
	cpr_pkg::ctrl_t      ctrl_c [N+1];
	logic signed [W-1:0] x_c    [N+1];
	logic signed [W-1:0] y_c    [N+1];
	logic        [31:0]  z_c    [N+1];
	logic                prep_ready;

	cpr_prep #(
		.GUARD (GUARD),
		.W     (W)
	) u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (bin_valid),
		.up_ready     (prep_ready),
		.op           (op),
		.real_in      (real_in),
		.imag_in      (imag_in),
		.magnitude_in (magnitude_in),
		.phase_in     (phase_in),
		.dn_valid     (v_c[0]),
		.dn_ready     (rdy_c[0]),
		.dn_ctrl      (ctrl_c[0]),
		.dn_x         (x_c[0]),
		.dn_y         (y_c[0]),
		.dn_z         (z_c[0])
	);

	assign bin_stall = !prep_ready;

	for (genvar k = 0; k < N; k++) begin : g_rot
		cpr_rot #(
			.STEP (k),
			.W    (W)
		) u_rot (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (v_c[k]),
			.up_ready (rdy_c[k]),
			.up_ctrl  (ctrl_c[k]),
			.up_x     (x_c[k]),
			.up_y     (y_c[k]),
			.up_z     (z_c[k]),
			.dn_valid (v_c[k+1]),
			.dn_ready (rdy_c[k+1]),
			.dn_ctrl  (ctrl_c[k+1]),
			.dn_x     (x_c[k+1]),
			.dn_y     (y_c[k+1]),
			.dn_z     (z_c[k+1])
		);
	end

	cpr_post #(
		.GUARD (GUARD),
		.W     (W)
	) u_post (
		.clk           (clk),
		.arst_n        (arst_n),
		.up_valid      (v_c[N]),
		.up_ready      (rdy_c[N]),
		.up_ctrl       (ctrl_c[N]),
		.up_x          (x_c[N]),
		.up_y          (y_c[N]),
		.up_z          (z_c[N]),
		.valid         (res_valid),
		.stall         (res_stall),
		.magnitude_out (magnitude_out),
		.phase_out     (phase_out),
		.real_out      (real_out),
		.imag_out      (imag_out)
	);

	// a free output side must leave the whole pipe free to take a beat
	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!res_stall |-> !bin_stall)
		else $error("input stalled while output side is free");

	// only one direction's fields may be non-zero in a result
	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((magnitude_out == 16'd0 && phase_out == 16'sd0) ||
		               (real_out == 17'sd0 && imag_out == 17'sd0)))
		else $error("result carries both polar and rectangular fields");

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (magnitude_out <= 16'd46341))
		else $error("magnitude above saturation limit");

	a_part_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (real_out <= 17'sd46341 && real_out >= -17'sd46341 &&
		               imag_out <= 17'sd46341 && imag_out >= -17'sd46341))
		else $error("rectangular part outside saturation limit");

endmodule

`default_nettype wire

>>> tb/cpr_check.sv
`timescale 1ns / 100ps

module cpr_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               bin_valid,
	input  logic               bin_stall,
	input  logic               op,
	input  logic signed [15:0] real_in,
	input  logic signed [15:0] imag_in,
	input  logic        [15:0] magnitude_in,
	input  logic signed [15:0] phase_in,
	input  logic               res_valid,
	input  logic               res_stall,
	input  logic        [15:0] magnitude_out,
	input  logic signed [15:0] phase_out,
	input  logic signed [16:0] real_out,
	input  logic signed [16:0] imag_out,
	output int                 mismatches,
	output int                 outstanding
);

	localparam int     GUARD     = cpr_pkg::WIDTH_DEF / 4;
	localparam int     STEPS     = (cpr_pkg::ITER_DEF < cpr_pkg::MAX_STEPS) ?
	                               cpr_pkg::ITER_DEF : cpr_pkg::MAX_STEPS;
	localparam longint GAIN      = longint'(cpr_pkg::GAIN_Q30);
	localparam longint PART_LIM  = longint'(cpr_pkg::MAG_LIMIT);

	typedef struct {
		logic        [15:0] magnitude;
		logic signed [15:0] phase;
		logic signed [16:0] re;
		logic signed [16:0] im;
	} bin_result_t;

	bin_result_t converted_bins[$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	function automatic longint clamp_part(longint v);
		if (v > PART_LIM)
			return PART_LIM;
		if (v < -PART_LIM)
			return -PART_LIM;
		return v;
	endfunction

	function automatic bin_result_t convert_bin(cpr_pkg::op_t o, logic signed [15:0] re_in,
			logic signed [15:0] im_in, logic [15:0] mag_in, logic signed [15:0] ph_in);
		bin_result_t r;
		longint      x, y, dx, dy, m, p, za;
		bit   [31:0] z;
		r = '{magnitude: '0, phase: '0, re: '0, im: '0};
		if (o == cpr_pkg::OP_POLAR) begin
			if (re_in == 0 && im_in == 0)
				return r;
			x = longint'(re_in) * (1 << GUARD);
			y = longint'(im_in) * (1 << GUARD);
			z = '0;
			// left half plane: turn by pi first
			if (x < 0) begin
				x = -x;
				y = -y;
				z = 32'h8000_0000;
			end
			for (int i = 0; i < STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx;
					y -= dy;
					z += cpr_pkg::ATAN_TAB[i];
				end else begin
					x -= dx;
					y += dy;
					z -= cpr_pkg::ATAN_TAB[i];
				end
			end
			m = (x * GAIN + (longint'(1) << (29 + GUARD))) >>> (30 + GUARD);
			if (m > PART_LIM)
				m = PART_LIM;
			if (m < 0)
				m = 0;
			z = z + 32'h8000;
			r.magnitude = m[15:0];
			r.phase     = z[31:16];
		end else begin
			m = longint'(mag_in);
			if (m > PART_LIM)
				m = PART_LIM;
			x = (m * (1 << GUARD) * GAIN + (longint'(1) << 29)) >>> 30;
			y = 0;
			p = longint'(ph_in);
			// fold into the right half plane
			if (p > cpr_pkg::HALF_PI) begin
				x = -x;
				p -= 32768;
			end else if (p < -cpr_pkg::HALF_PI) begin
				x = -x;
				p += 32768;
			end
			za = p * 65536;
			for (int i = 0; i < STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (za >= 0) begin
					x -= dx;
					y += dy;
					za -= longint'(cpr_pkg::ATAN_TAB[i]);
				end else begin
					x += dx;
					y -= dy;
					za += longint'(cpr_pkg::ATAN_TAB[i]);
				end
			end
			x = clamp_part((x + (longint'(1) << (GUARD - 1))) >>> GUARD);
			y = clamp_part((y + (longint'(1) << (GUARD - 1))) >>> GUARD);
			r.re = x[16:0];
			r.im = y[16:0];
		end
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		bin_result_t want;
		if (arst_n) begin
			if (bin_valid && !bin_stall)
				converted_bins.push_back(convert_bin(cpr_pkg::op_t'(op), real_in, imag_in,
					magnitude_in, phase_in));
			if (res_valid && !res_stall) begin
				if (converted_bins.size() == 0) begin
					report("result beat with no bin pending", 0, 0);
				end else begin
					want = converted_bins.pop_front();
					if (magnitude_out !== want.magnitude)
						report("magnitude_out", longint'(magnitude_out), longint'(want.magnitude));
					if (phase_out !== want.phase)
						report("phase_out", longint'(phase_out), longint'(want.phase));
					if (real_out !== want.re)
						report("real_out", longint'(real_out), longint'(want.re));
					if (imag_out !== want.im)
						report("imag_out", longint'(imag_out), longint'(want.im));
				end
			end
			outstanding <= converted_bins.size();
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int RANDOM_BINS    = 1250;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = cpr_pkg::ITER_DEF + 12;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               bin_valid    = 1'b0;
	logic               op           = cpr_pkg::OP_POLAR;
	logic signed [15:0] real_in      = '0;
	logic signed [15:0] imag_in      = '0;
	logic        [15:0] magnitude_in = '0;
	logic signed [15:0] phase_in     = '0;
	logic               res_stall    = 1'b0;
	logic               bin_stall;
	logic               res_valid;
	logic        [15:0] magnitude_out;
	logic signed [15:0] phase_out;
	logic signed [16:0] real_out;
	logic signed [16:0] imag_out;
	int                 mismatches;
	int                 outstanding;
	int                 idle_cycles  = 0;
	int                 stall_run    = 0;

	cordic_polar_rect_convert u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.bin_valid     (bin_valid),
		.bin_stall     (bin_stall),
		.op            (op),
		.real_in       (real_in),
		.imag_in       (imag_in),
		.magnitude_in  (magnitude_in),
		.phase_in      (phase_in),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.magnitude_out (magnitude_out),
		.phase_out     (phase_out),
		.real_out      (real_out),
		.imag_out      (imag_out)
	);

	cpr_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.bin_valid     (bin_valid),
		.bin_stall     (bin_stall),
		.op            (op),
		.real_in       (real_in),
		.imag_in       (imag_in),
		.magnitude_in  (magnitude_in),
		.phase_in      (phase_in),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.magnitude_out (magnitude_out),
		.phase_out     (phase_out),
		.real_out      (real_out),
		.imag_out      (imag_out),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: long open stretches, short stall bursts, the odd long hold
	always @(posedge clk or negedge arst_n) begin
		int pick;
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_run <= 0;
		end else if (stall_run == 0) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				res_stall <= 1'b0;
				stall_run <= $urandom_range(1, 40);
			end else if (pick < 8) begin
				res_stall <= 1'b1;
				stall_run <= $urandom_range(1, 6);
			end else begin
				res_stall <= 1'b1;
				stall_run <= $urandom_range(10, 20);
			end
		end else begin
			stall_run <= stall_run - 1;
		end
	end

	always @(posedge clk) begin
		if ((bin_valid && !bin_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// called just after a rising edge; returns just after the edge that takes the beat
	task automatic send_bin(cpr_pkg::op_t o, logic signed [15:0] re, logic signed [15:0] im,
			logic [15:0] mag, logic signed [15:0] ph);
		bit ready;
		op           <= o;
		real_in      <= re;
		imag_in      <= im;
		magnitude_in <= mag;
		phase_in     <= ph;
		bin_valid    <= 1'b1;
		do begin
			@(negedge clk);
			ready = !bin_stall;
			@(posedge clk);
		end while (!ready);
	endtask

	function automatic logic signed [15:0] pick_part();
		case ($urandom_range(0, 9))
			0, 1:    return 16'($urandom_range(0, 127) - 64);
			2: begin
				case ($urandom_range(0, 5))
					0:       return -16'sd32768;
					1:       return -16'sd32767;
					2:       return -16'sd1;
					3:       return 16'sd0;
					4:       return 16'sd1;
					default: return 16'sd32767;
				endcase
			end
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_magnitude();
		case ($urandom_range(0, 19))
			0, 1, 2: return 16'($urandom_range(0, 65535));
			3, 4, 5: return 16'($urandom_range(46000, cpr_pkg::MAG_LIMIT));
			default: return 16'($urandom_range(0, cpr_pkg::MAG_LIMIT));
		endcase
	endfunction

	function automatic logic signed [15:0] pick_phase();
		if ($urandom_range(0, 7) != 0)
			return 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 6))
			0:       return -16'sd32768;
			1:       return -16'sd16385;
			2:       return -16'sd16384;
			3:       return 16'sd0;
			4:       return 16'sd16384;
			5:       return 16'sd16385;
			default: return 16'sd32767;
		endcase
	endfunction

	task automatic send_random_bin();
		cpr_pkg::op_t o;
		o = ($urandom_range(0, 1) == 0) ? cpr_pkg::OP_POLAR : cpr_pkg::OP_RECT;
		// fields the op does not use still get random values
		if (o == cpr_pkg::OP_POLAR)
			send_bin(o, pick_part(), pick_part(), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
		else
			send_bin(o, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				pick_magnitude(), pick_phase());
	endtask

	initial begin
		int gap;
		int burst_left;
		burst_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rectangular to polar: zero, axes, corners, phase right at +/- pi
		send_bin(cpr_pkg::OP_POLAR, 16'sd0, 16'sd0, 16'hFFFF, -16'sd1);
		send_bin(cpr_pkg::OP_POLAR, 16'sd32767, 16'sd0, 16'h0000, 16'sd0);
		send_bin(cpr_pkg::OP_POLAR, -16'sd32768, 16'sd0, 16'h0000, 16'sd0);
		send_bin(cpr_pkg::OP_POLAR, 16'sd0, 16'sd32767, 16'h0000, 16'sd0);
		send_bin(cpr_pkg::OP_POLAR, 16'sd0, -16'sd32768, 16'h0000, 16'sd0);
		send_bin(cpr_pkg::OP_POLAR, -16'sd32768, -16'sd32768, 16'h0000, 16'sd0);
		send_bin(cpr_pkg::OP_POLAR, 16'sd32767, 16'sd32767, 16'h0000, 16'sd0);
		send_bin(cpr_pkg::OP_POLAR, -16'sd32768, 16'sd32767, 16'h0000, 16'sd0);
		send_bin(cpr_pkg::OP_POLAR, 16'sd32767, -16'sd32768, 16'h0000, 16'sd0);
		send_bin(cpr_pkg::OP_POLAR, -16'sd1, 16'sd0, 16'h0000, 16'sd0);
		send_bin(cpr_pkg::OP_POLAR, -16'sd32768, 16'sd1, 16'h0000, 16'sd0);
		send_bin(cpr_pkg::OP_POLAR, -16'sd32768, -16'sd1, 16'h0000, 16'sd0);
		send_bin(cpr_pkg::OP_POLAR, 16'sd1, 16'sd1, 16'h0000, 16'sd0);
		send_bin(cpr_pkg::OP_POLAR, -16'sd1, -16'sd1, 16'h0000, 16'sd0);
		// polar to rectangular: clamp, quadrant fold edges, full scale
		send_bin(cpr_pkg::OP_RECT, -16'sd1, -16'sd1, 16'd0, 16'sd12345);
		send_bin(cpr_pkg::OP_RECT, 16'sd0, 16'sd0, 16'd46341, 16'sd0);
		send_bin(cpr_pkg::OP_RECT, 16'sd0, 16'sd0, 16'hFFFF, 16'sd0);
		send_bin(cpr_pkg::OP_RECT, 16'sd0, 16'sd0, 16'd46342, 16'sd16384);
		send_bin(cpr_pkg::OP_RECT, 16'sd0, 16'sd0, 16'd32768, 16'sd16385);
		send_bin(cpr_pkg::OP_RECT, 16'sd0, 16'sd0, 16'd46341, -16'sd16384);
		send_bin(cpr_pkg::OP_RECT, 16'sd0, 16'sd0, 16'd46341, -16'sd16385);
		send_bin(cpr_pkg::OP_RECT, 16'sd0, 16'sd0, 16'd46341, 16'sd32767);
		send_bin(cpr_pkg::OP_RECT, 16'sd0, 16'sd0, 16'hFFFF, -16'sd32768);
		send_bin(cpr_pkg::OP_RECT, 16'sd0, 16'sd0, 16'd32767, 16'sd8192);

		for (int n = 0; n < RANDOM_BINS; n++) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					bin_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
					: $urandom_range(1, 20);
			end
			burst_left--;
			send_random_bin();
		end
		bin_valid <= 1'b0;

		// the checker's count settles after the edge that took the last beat
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
